### rtl/fsfe_pkg.sv
// ---------------------------------------------------------------------------
// fsfe_pkg
// Shared types and constants of the frame store shape fill engine.
// ---------------------------------------------------------------------------
`default_nettype none
package fsfe_pkg;
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int CNT_W = 15;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] MODE_RECT = 2'd0;
  localparam logic [1:0] MODE_DISC = 2'd1;
  localparam logic [1:0] MODE_FADE = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [10:0]        size_x;
    logic [10:0]        size_y;
    logic [9:0]         radius;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [8:0]         fade_gain;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       read_red;
    logic [7:0]       read_green;
    logic [7:0]       read_blue;
    logic [CNT_W-1:0] pixels_written;
  } res_t;
endpackage
`default_nettype wire

### rtl/fsfe_ram.sv
// ---------------------------------------------------------------------------
// fsfe_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module fsfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/framebuffer_shape_fill_engine.sv
// ---------------------------------------------------------------------------
// framebuffer_shape_fill_engine
// Rectangle / disc fill, fade and pixel read on a 24-bit RGB frame store.
// ---------------------------------------------------------------------------
// After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT pixels
// while in_ready stays low. Each fill or fade scans its clipped bounding box
// one pixel per cycle through the single frame store write port; a fade
// covers the active frame area, and each pixel is read in the cycle before
// its write back. A read scans no box, and empty boxes skip the scan.
// One result per command.
`default_nettype none
module framebuffer_shape_fill_engine (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire fsfe_pkg::cmd_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output fsfe_pkg::res_t       out_data,
  input  wire logic            cfg_we,
  input  wire logic [fsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fsfe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fsfe_pkg::*;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SETUP, ST_SCAN, ST_RDWAIT, ST_DONE}
    state_t;

  state_t state_r;
  logic [7:0] fw_r, fh_r;
  cmd_t cmd_r;
  logic [AW-1:0] clr_r;
  // box bounds, signed 14 bit
  logic signed [13:0] x0_r, x1_r, y0_r, y1_r;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [CNT_W-1:0] cnt_r;
  logic [8:0] gain_r;
  logic rr2_r;
  // pipeline from read to write (fade), one stage
  logic pv_r;
  logic [AW-1:0] pa_r;
  logic [19:0] rsq_r;

  // active extents
  logic [10:0] aw, ah;
  assign aw = (fw_r > 8'(MAX_WIDTH))  ? 11'(MAX_WIDTH)  : {3'd0, fw_r};
  assign ah = (fh_r > 8'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : {3'd0, fh_r};

  // setup bounds from input
  logic signed [13:0] bx0, bx1, by0, by1, cx0, cx1, cy0, cy1;
  always_comb begin
    if (in_data.mode == MODE_RECT) begin
      bx0 = 14'(in_data.pos_x);
      by0 = 14'(in_data.pos_y);
      bx1 = 14'(in_data.pos_x) + 14'($signed({1'b0, in_data.size_x}));
      by1 = 14'(in_data.pos_y) + 14'($signed({1'b0, in_data.size_y}));
    end else if (in_data.mode == MODE_DISC) begin
      bx0 = 14'(in_data.pos_x) - 14'($signed({1'b0, in_data.radius}));
      by0 = 14'(in_data.pos_y) - 14'($signed({1'b0, in_data.radius}));
      bx1 = 14'(in_data.pos_x) + 14'($signed({1'b0, in_data.radius}));
      by1 = 14'(in_data.pos_y) + 14'($signed({1'b0, in_data.radius}));
    end else begin
      bx0 = '0;
      by0 = '0;
      bx1 = 14'($signed({3'd0, aw})) - 14'sd1;
      by1 = 14'($signed({3'd0, ah})) - 14'sd1;
    end
    cx0 = (bx0 < 0) ? 14'sd0 : bx0;
    cy0 = (by0 < 0) ? 14'sd0 : by0;
    cx1 = (bx1 > 14'($signed({3'd0, aw})) - 14'sd1) ? 14'($signed({3'd0, aw})) - 14'sd1 : bx1;
    cy1 = (by1 > 14'($signed({3'd0, ah})) - 14'sd1) ? 14'($signed({3'd0, ah})) - 14'sd1 : by1;
  end

  // disc test: dx, dy registered separately would be costlier; use two muls
  logic signed [13:0] dx, dy;
  logic [19:0] dx2, dy2;
  logic [20:0] dsum;
  logic inside_px;
  assign dx = 14'($signed({1'b0, x_r})) - 14'(cmd_r.pos_x);
  assign dy = 14'($signed({1'b0, y_r})) - 14'(cmd_r.pos_y);
  assign dx2 = 20'(dx * dx);
  assign dy2 = 20'(dy * dy);
  assign dsum = {1'b0, dx2} + {1'b0, dy2};
  assign inside_px = (cmd_r.mode != MODE_DISC) || (dsum <= {1'b0, rsq_r});

  // RAM
  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [23:0] ram_wd, ram_rd;
  logic [AW-1:0] cur_a;
  assign cur_a = {y_r, x_r};

  logic [15:0] pr, pg, pb;
  assign pr = ram_rd[23:16] * gain_r;
  assign pg = ram_rd[15:8] * gain_r;
  assign pb = ram_rd[7:0] * gain_r;

  logic last_x, last_y, scan_px;
  assign last_x = (14'($signed({1'b0, x_r})) == x1_r);
  assign last_y = (14'($signed({1'b0, y_r})) == y1_r);
  assign scan_px = (state_r == ST_SCAN);

  always_comb begin
    ram_we = 1'b0;
    ram_wa = cur_a;
    ram_wd = {cmd_r.red, cmd_r.green, cmd_r.blue};
    ram_ra = cur_a;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_wa = clr_r;
      ram_wd = '0;
    end else if (pv_r) begin
      ram_we = 1'b1;
      ram_wa = pa_r;
      ram_wd = {8'(ram_rd[23:16] - pr[15:8]), 8'(ram_rd[15:8] - pg[15:8]),
                8'(ram_rd[7:0] - pb[15:8])};
    end else if (scan_px && cmd_r.mode != MODE_FADE) begin
      ram_we = inside_px;
    end
    // hold the read address until the pixel is captured
    if (state_r == ST_SETUP || (cmd_r.mode == MODE_READ &&
        (state_r == ST_RDWAIT || state_r == ST_DONE))) begin
      ram_ra = {cmd_r.pos_y[YW-1:0], cmd_r.pos_x[XW-1:0]};
    end
  end

  fsfe_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_wa),
    .wdata(ram_wd),
    .raddr(ram_ra),
    .rdata(ram_rd)
  );

  logic wr_cnt;
  assign wr_cnt = pv_r || (scan_px && cmd_r.mode != MODE_FADE && inside_px);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      fw_r      <= 8'd128;
      fh_r      <= 8'd128;
      clr_r     <= '0;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
      pv_r      <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_FRAME_WIDTH) begin
        fw_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_FRAME_HEIGHT) begin
        fh_r <= cfg_data;
      end
      if (pv_r) begin
        pv_r <= 1'b0;
      end
      if (wr_cnt && cnt_r != CNT_MAX) begin
        cnt_r <= cnt_r + 1'b1;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r  <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            in_ready <= 1'b0;
            cmd_r    <= in_data;
            x0_r     <= cx0;
            x1_r     <= cx1;
            y0_r     <= cy0;
            y1_r     <= cy1;
            x_r      <= cx0[XW-1:0];
            y_r      <= cy0[YW-1:0];
            cnt_r    <= '0;
            gain_r   <= (in_data.fade_gain > 9'd256) ? 9'd256 : in_data.fade_gain;
            rsq_r    <= 20'(in_data.radius * in_data.radius);
            state_r  <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          rr2_r <= (cmd_r.pos_x >= 0) && (cmd_r.pos_y >= 0) &&
                   (14'(cmd_r.pos_x) < 14'($signed({3'd0, aw}))) &&
                   (14'(cmd_r.pos_y) < 14'($signed({3'd0, ah})));
          if (cmd_r.mode == MODE_READ) begin
            state_r <= ST_RDWAIT;
          end else if (x0_r > x1_r || y0_r > y1_r) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cmd_r.mode == MODE_FADE) begin
            pv_r <= 1'b1;
            pa_r <= cur_a;
          end
          if (last_x) begin
            x_r <= x0_r[XW-1:0];
            if (last_y) begin
              state_r <= ST_RDWAIT;
            end else begin
              y_r <= y_r + 1'b1;
            end
          end else begin
            x_r <= x_r + 1'b1;
          end
        end
        ST_RDWAIT: begin
          if (!pv_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (cmd_r.mode == MODE_READ && rr2_r) begin
              out_data.read_red   <= ram_rd[23:16];
              out_data.read_green <= ram_rd[15:8];
              out_data.read_blue  <= ram_rd[7:0];
            end else begin
              out_data.read_red   <= '0;
              out_data.read_green <= '0;
              out_data.read_blue  <= '0;
            end
            out_data.pixels_written <= cnt_r;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE && !out_valid))
    else $error("in_ready high while busy");
  a_read_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cmd_r.mode == MODE_READ) |-> out_data.pixels_written == '0)
    else $error("read reported writes");
  a_fade_wb_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(state_r == ST_SCAN))
    else $error("fade write back without scan");
`endif
endmodule
`default_nettype wire

### tb/sv/framebuffer_shape_fill_engine_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// framebuffer_shape_fill_engine_tb
// Drives drawing commands into the shape fill engine and checks every result
// against a pixel-accurate frame store model kept inside the testbench.
// Covers rectangle and disc fills, fades, pixel reads, clipping, frame size
// changes, long output back-pressure and random command mixes.
// ---------------------------------------------------------------------------
module framebuffer_shape_fill_engine_tb;
  import fsfe_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [23:0] pixel_mem [DEPTH];
  logic [7:0] width_reg, height_reg;
  res_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit quiet = 1'b0;

  framebuffer_shape_fill_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic res_t draw_pixels(cmd_t c);
    res_t r;
    int w, h, x0, x1, y0, y1, px, py, rad, cnt, dx, dy, g;
    logic [23:0] p, colour;
    logic [7:0] ch [3];
    r = '0;
    cnt = 0;
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    px = c.pos_x;
    py = c.pos_y;
    rad = c.radius;
    colour = {c.red, c.green, c.blue};
    if (c.mode == MODE_RECT || c.mode == MODE_DISC) begin
      if (c.mode == MODE_RECT) begin
        x0 = px; x1 = px + int'(c.size_x);
        y0 = py; y1 = py + int'(c.size_y);
      end else begin
        x0 = px - rad; x1 = px + rad;
        y0 = py - rad; y1 = py + rad;
      end
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > w - 1) x1 = w - 1;
      if (y1 > h - 1) y1 = h - 1;
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++) begin
          dx = x - px;
          dy = y - py;
          if (c.mode == MODE_DISC && dx * dx + dy * dy > rad * rad) continue;
          pixel_mem[y * MAX_WIDTH + x] = colour;
          cnt++;
        end
    end else if (c.mode == MODE_FADE) begin
      g = (c.fade_gain > 256) ? 256 : c.fade_gain;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          p = pixel_mem[y * MAX_WIDTH + x];
          ch[0] = p[23:16]; ch[1] = p[15:8]; ch[2] = p[7:0];
          for (int k = 0; k < 3; k++) ch[k] = ch[k] - ((int'(ch[k]) * g) >> 8);
          pixel_mem[y * MAX_WIDTH + x] = {ch[0], ch[1], ch[2]};
          cnt++;
        end
    end else if (px >= 0 && px < w && py >= 0 && py < h) begin
      p = pixel_mem[py * MAX_WIDTH + px];
      r.read_red = p[23:16];
      r.read_green = p[15:8];
      r.read_blue = p[7:0];
    end
    r.pixels_written = (cnt > 32767) ? CNT_MAX : cnt[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_result(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.read_red !== want.read_red) begin
      $display("%0t read_red exp %0d got %0d", $time, want.read_red, got.read_red);
      errors++;
    end
    if (got.read_green !== want.read_green) begin
      $display("%0t read_green exp %0d got %0d", $time, want.read_green, got.read_green);
      errors++;
    end
    if (got.read_blue !== want.read_blue) begin
      $display("%0t read_blue exp %0d got %0d", $time, want.read_blue, got.read_blue);
      errors++;
    end
    if (got.pixels_written !== want.pixels_written) begin
      $display("%0t pixels_written exp %0d got %0d", $time, want.pixels_written,
               got.pixels_written);
      errors++;
    end
  endtask

  // result sink with random stalls and long hold-offs
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_cmd(cmd_t c);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(draw_pixels(c));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic set_frame(logic [7:0] w, logic [7:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  function automatic cmd_t mk(logic [1:0] m, int x, int y, int sx = 0, int sy = 0,
                              int rad = 0, logic [23:0] rgb = '0, int g = 0);
    cmd_t c;
    c = '{default: '0};
    c.mode = m;
    c.pos_x = 12'(x);
    c.pos_y = 12'(y);
    c.size_x = 11'(sx);
    c.size_y = 11'(sy);
    c.radius = 10'(rad);
    {c.red, c.green, c.blue} = rgb;
    c.fade_gain = 9'(g);
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int w, h, sel;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    c = rnd[$bits(cmd_t)-1:0];
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    sel = $urandom_range(0, 99);
    c.mode = (sel < 35) ? MODE_RECT : (sel < 60) ? MODE_DISC :
             (sel < 92) ? MODE_READ : MODE_FADE;
    if ($urandom_range(0, 5) != 0) begin
      c.pos_x = 12'(int'($urandom_range(0, w + 20)) - 10);
      c.pos_y = 12'(int'($urandom_range(0, h + 20)) - 10);
      c.size_x = 11'($urandom_range(0, 30));
      c.size_y = 11'($urandom_range(0, 30));
      c.radius = 10'($urandom_range(0, 20));
    end
    return c;
  endfunction

  task automatic test_fills_and_reads();
    send_cmd(mk(MODE_READ, 0, 0));
    send_cmd(mk(MODE_RECT, -2048, -2048, 2047, 2047, 0, 24'hFFFFFF));
    send_cmd(mk(MODE_READ, 127, 127));
    send_cmd(mk(MODE_RECT, 2047, 2047, 2047, 2047, 0, 24'h123456));
    send_cmd(mk(MODE_RECT, 5, 7, 0, 0, 0, 24'h000000));
    send_cmd(mk(MODE_READ, 5, 7));
    send_cmd(mk(MODE_RECT, 120, 3, 20, 2, 0, 24'hA5C3E1));
    send_cmd(mk(MODE_DISC, 64, 64, 0, 0, 10, 24'h00FF80));
    send_cmd(mk(MODE_DISC, 3, 3, 0, 0, 0, 24'h8001FE));
    send_cmd(mk(MODE_DISC, -2048, -2048, 0, 0, 1023, 24'h5A5A5A));
    send_cmd(mk(MODE_DISC, 2047, -5, 0, 0, 1023, 24'h0F0F0F));
    send_cmd(mk(MODE_READ, 64, 74));
    send_cmd(mk(MODE_READ, -1, 0));
    send_cmd(mk(MODE_READ, 128, 5));
    send_cmd(mk(MODE_READ, -2048, 2047));
    send_cmd(mk(MODE_FADE, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(MODE_FADE, 0, 0, 0, 0, 0, 0, 128));
    send_cmd(mk(MODE_READ, 64, 64));
    send_cmd(mk(MODE_READ, 121, 4));
    send_cmd(mk(MODE_FADE, 0, 0, 0, 0, 0, 0, 511));
    send_cmd(mk(MODE_READ, 64, 64));
  endtask

  task automatic test_frame_sizes();
    set_frame(8'd0, 8'd0);
    send_cmd(mk(MODE_RECT, 0, 0, 10, 10, 0, 24'hFFFFFF));
    send_cmd(mk(MODE_READ, 0, 0));
    set_frame(8'd255, 8'd1);
    send_cmd(mk(MODE_RECT, -3, -3, 300, 300, 0, 24'h336699));
    send_cmd(mk(MODE_FADE, 0, 0, 0, 0, 0, 0, 300));
    set_frame(8'd1, 8'd255);
    send_cmd(mk(MODE_DISC, 0, 20, 0, 0, 4, 24'hFEDCBA));
    send_cmd(mk(MODE_READ, 0, 20));
    set_frame(8'd128, 8'd128);
    send_cmd(mk(MODE_READ, 0, 20));
    send_cmd(mk(MODE_READ, 1, 20));
  endtask

  task automatic test_backpressure();
    set_frame(8'd16, 8'd16);
    hold_left = 400;
    repeat (12) send_cmd(random_cmd());
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 2) set_frame(8'd128, 8'd128);
      else set_frame(8'($urandom_range(1, 48)), 8'($urandom_range(1, 48)));
      if (ph == 4) quiet = 1'b1;
      repeat (12) send_cmd(random_cmd());
    end
  endtask

  initial begin
    width_reg = 8'd128;
    height_reg = 8'd128;
    for (int i = 0; i < DEPTH; i++) pixel_mem[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fills_and_reads();
    test_frame_sizes();
    test_backpressure();
    test_random();
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

### framebuffer_shape_fill_engine.f
rtl/fsfe_pkg.sv
rtl/fsfe_ram.sv
rtl/framebuffer_shape_fill_engine.sv
tb/sv/framebuffer_shape_fill_engine_tb.sv
